// ===== sv/twt_pkg.sv =====
// ----------------------------------------------------------------------------
// twt_pkg
// types, constants and character classes shared by the word tokenizer modules
// ----------------------------------------------------------------------------
package twt_pkg;

  localparam int MAX_WORD   = 64;
  localparam int LEN_W      = $clog2(MAX_WORD + 1);
  localparam int RING_DEPTH = 2 * MAX_WORD;
  localparam int ADDR_W     = $clog2(RING_DEPTH);
  localparam int PTR_W      = ADDR_W + 1;
  localparam int OFF_W      = 32;
  localparam int CNT_W      = 32;
  localparam int DESC_DEPTH = 4;
  localparam int DPTR_W     = $clog2(DESC_DEPTH) + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_W      = 7;

  localparam logic [7:0] CH_HYPHEN = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_CASE   = 8'h20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALLOW_SINGLE = 2'd0,
    CFG_KEEP_NUMERIC = 2'd1,
    CFG_MAX_WORD_LEN = 2'd2,
    CFG_FOLD_CASE    = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } item_t;

  typedef struct packed {
    logic [7:0]       word_char;
    logic             last_char;
    logic [CNT_W-1:0] word_number;
    logic [31:0]      start_offset;
    logic [31:0]      end_offset;
  } result_t;

  // one kept word, chars already sitting in the ring
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [CNT_W-1:0] word_number;
    logic [31:0]      start_offset;
    logic [31:0]      end_offset;
  } desc_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } char_wr_t;

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h7A);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return is_upper(c) || is_lower(c);
  endfunction

  function automatic logic is_word_char(input logic [7:0] c);
    return is_letter(c) || ((c >= 8'h30) && (c <= 8'h39)) || (c == CH_SLASH) ||
           (c == CH_UNDER);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

// ===== sv/twt_front.sv =====
// ----------------------------------------------------------------------------
// twt_front
// config registers, byte classification, word assembly and keep/drop decision
// ----------------------------------------------------------------------------
module twt_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [twt_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [twt_pkg::CFG_W-1:0]        wr_data,
  input  logic                             push,
  output logic                             full,
  input  twt_pkg::item_t                   item,
  output twt_pkg::char_wr_t                char_wr,
  input  logic [twt_pkg::PTR_W-1:0]        tail,
  output logic                             desc_push,
  output twt_pkg::desc_t                   desc,
  input  logic                             desc_full
);

  localparam logic [twt_pkg::CFG_W-1:0] CAP_MAX = twt_pkg::CFG_W'(twt_pkg::MAX_WORD);

  logic                           allow_single;
  logic                           keep_numeric;
  logic [twt_pkg::CFG_W-1:0]      max_word_len;
  logic                           fold_case;

  logic [twt_pkg::LEN_W-1:0]      word_length;
  logic                           has_letter;
  logic [twt_pkg::LEN_W-1:0]      first_letter;
  logic                           after_hyphen;
  logic [twt_pkg::OFF_W-1:0]      byte_offset;
  logic [twt_pkg::OFF_W-1:0]      word_start;
  logic [twt_pkg::CNT_W-1:0]      words_emitted;
  logic [twt_pkg::PTR_W-1:0]      base;

  logic                           accept;
  logic [7:0]                     b;
  logic [7:0]                     c;
  logic                           skip;
  logic                           hyphen;
  logic                           wordc;
  logic                           other;
  logic                           do_write;
  logic                           close_sep;
  logic                           close_end;
  logic                           close_now;
  logic [twt_pkg::LEN_W-1:0]      cap;
  logic [twt_pkg::LEN_W-1:0]      word_length_next;
  logic                           has_letter_next;
  logic [twt_pkg::LEN_W-1:0]      first_letter_next;
  logic [twt_pkg::LEN_W-1:0]      len;
  logic                           letter;
  logic                           keep;
  logic [twt_pkg::OFF_W-1:0]      word_start_next;
  logic [twt_pkg::OFF_W-1:0]      offset_inc;
  logic [twt_pkg::PTR_W-1:0]      wr_ptr;
  logic [twt_pkg::PTR_W-1:0]      ring_used;

  // config port
  always_ff @(posedge clk) begin
    if (rst) begin
      allow_single <= 1'b0;
      keep_numeric <= 1'b0;
      max_word_len <= CAP_MAX;
      fold_case    <= 1'b1;
    end else if (wr_en) begin
      unique case (twt_pkg::cfg_index_t'(wr_index))
        twt_pkg::CFG_ALLOW_SINGLE: allow_single <= wr_data[0];
        twt_pkg::CFG_KEEP_NUMERIC: keep_numeric <= wr_data[0];
        twt_pkg::CFG_MAX_WORD_LEN: max_word_len <= wr_data;
        twt_pkg::CFG_FOLD_CASE:    fold_case    <= wr_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (max_word_len == '0) begin
      cap = twt_pkg::LEN_W'(1);
    end else if (max_word_len > CAP_MAX) begin
      cap = twt_pkg::LEN_W'(twt_pkg::MAX_WORD);
    end else begin
      cap = twt_pkg::LEN_W'(max_word_len);
    end
  end

  assign wr_ptr    = base + twt_pkg::PTR_W'(word_length);
  assign ring_used = wr_ptr - tail;
  assign full      = (ring_used == twt_pkg::PTR_W'(twt_pkg::RING_DEPTH)) || desc_full;
  assign accept    = push && !full;

  assign b = item.text_byte;
  assign c = (fold_case && twt_pkg::is_upper(b)) ? (b | twt_pkg::CH_CASE) : b;

  assign skip     = after_hyphen && twt_pkg::is_blank(b);
  assign hyphen   = !skip && (word_length != '0) && (b == twt_pkg::CH_HYPHEN);
  assign wordc    = !skip && !hyphen && twt_pkg::is_word_char(c);
  assign other    = !skip && !hyphen && !twt_pkg::is_word_char(c);
  assign do_write = wordc && (word_length < cap);

  assign word_length_next  = word_length + twt_pkg::LEN_W'(do_write);
  assign has_letter_next   = has_letter || (do_write && twt_pkg::is_letter(c));
  assign first_letter_next = (do_write && twt_pkg::is_letter(c) && !has_letter) ?
                             word_length : first_letter;
  assign word_start_next   = (wordc && (word_length == '0)) ? byte_offset : word_start;
  assign offset_inc        = byte_offset + twt_pkg::OFF_W'(1);

  assign close_sep = other && (word_length != '0);
  assign close_end = item.end_of_text && !close_sep && (word_length_next != '0);
  assign close_now = accept && (close_sep || close_end);

  // cap may have been lowered since the word began
  assign len    = (word_length_next > cap) ? cap : word_length_next;
  assign letter = has_letter_next && (first_letter_next < len);
  assign keep   = !(((len < twt_pkg::LEN_W'(2)) && !allow_single) ||
                    (!letter && !keep_numeric));

  assign desc_push         = close_now && keep;
  assign desc.len          = len;
  assign desc.word_number  = words_emitted;
  assign desc.start_offset = word_start_next[31:0];
  assign desc.end_offset   = close_sep ? byte_offset[31:0] : offset_inc[31:0];

  assign char_wr.en   = accept && do_write;
  assign char_wr.addr = wr_ptr[twt_pkg::ADDR_W-1:0];
  assign char_wr.data = c;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_length   <= '0;
      has_letter    <= 1'b0;
      first_letter  <= '0;
      after_hyphen  <= 1'b0;
      byte_offset   <= '0;
      word_start    <= '0;
      words_emitted <= '0;
      base          <= '0;
    end else if (accept) begin
      if (desc_push) begin
        base <= base + twt_pkg::PTR_W'(len);
      end
      if (close_now || item.end_of_text) begin
        word_length <= '0;
        has_letter  <= 1'b0;
      end else begin
        word_length <= word_length_next;
        has_letter  <= has_letter_next;
      end
      first_letter <= first_letter_next;
      if (item.end_of_text) begin
        after_hyphen  <= 1'b0;
        byte_offset   <= '0;
        word_start    <= '0;
        words_emitted <= '0;
      end else begin
        after_hyphen  <= skip ? after_hyphen : hyphen;
        byte_offset   <= offset_inc;
        word_start    <= word_start_next;
        words_emitted <= words_emitted + twt_pkg::CNT_W'(desc_push);
      end
    end
  end

  a_ring_bound: assert property (@(posedge clk) disable iff (rst)
    ring_used <= twt_pkg::PTR_W'(twt_pkg::RING_DEPTH))
    else $error("char ring overfilled");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    word_length <= twt_pkg::LEN_W'(twt_pkg::MAX_WORD))
    else $error("word length beyond buffer");

  a_eot_clear: assert property (@(posedge clk) disable iff (rst)
    accept && item.end_of_text |=> (byte_offset == '0) && (word_length == '0) &&
                                   (words_emitted == '0))
    else $error("document state not cleared at end of text");

endmodule

// ===== sv/twt_desc_fifo.sv =====
// ----------------------------------------------------------------------------
// twt_desc_fifo
// short queue of kept-word descriptors between front and back
// ----------------------------------------------------------------------------
module twt_desc_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  twt_pkg::desc_t wdata,
  output logic           full,
  input  logic           rd,
  output twt_pkg::desc_t rdata,
  output logic           valid
);

  localparam int IDX_W = twt_pkg::DPTR_W - 1;

  twt_pkg::desc_t               slots [twt_pkg::DESC_DEPTH];
  logic [twt_pkg::DPTR_W-1:0]   wptr;
  logic [twt_pkg::DPTR_W-1:0]   rptr;

  assign valid = (wptr != rptr);
  assign full  = (wptr[IDX_W-1:0] == rptr[IDX_W-1:0]) &&
                 (wptr[IDX_W] != rptr[IDX_W]);
  assign rdata = slots[rptr[IDX_W-1:0]];

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      slots[wptr[IDX_W-1:0]] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
    end else begin
      if (wr && !full) begin
        wptr <= wptr + twt_pkg::DPTR_W'(1);
      end
      if (rd && valid) begin
        rptr <= rptr + twt_pkg::DPTR_W'(1);
      end
    end
  end

endmodule

// ===== sv/twt_back.sv =====
// ----------------------------------------------------------------------------
// twt_back
// char ring memory and per-character emitter with result register
// ----------------------------------------------------------------------------
module twt_back (
  input  logic                       clk,
  input  logic                       rst,
  input  twt_pkg::char_wr_t          char_wr,
  output logic [twt_pkg::PTR_W-1:0]  tail,
  input  twt_pkg::desc_t             desc,
  input  logic                       desc_valid,
  output logic                       desc_pop,
  output twt_pkg::result_t           result,
  output logic                       empty,
  input  logic                       pop
);

  logic [7:0]                  ring [twt_pkg::RING_DEPTH];
  logic [7:0]                  rd_data;
  logic                        rd_pend;
  logic                        rd_last;
  logic [twt_pkg::CNT_W-1:0]   rd_word_number;
  logic [31:0]                 rd_start;
  logic [31:0]                 rd_end;
  logic [twt_pkg::LEN_W-1:0]   k;
  logic                        out_valid;
  logic                        pop_fire;
  logic                        issue;
  logic                        last;

  assign empty    = !out_valid;
  assign pop_fire = pop && out_valid;
  assign issue    = desc_valid && !rd_pend && (!out_valid || pop);
  assign last     = (k + twt_pkg::LEN_W'(1)) == desc.len;
  assign desc_pop = issue && last;

  always_ff @(posedge clk) begin
    if (char_wr.en) begin
      ring[char_wr.addr] <= char_wr.data;
    end
    if (issue) begin
      rd_data <= ring[tail[twt_pkg::ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_last        <= last;
      rd_word_number <= desc.word_number;
      rd_start       <= desc.start_offset;
      rd_end         <= desc.end_offset;
    end
    if (rd_pend) begin
      result.word_char    <= rd_data;
      result.last_char    <= rd_last;
      result.word_number  <= rd_word_number;
      result.start_offset <= rd_start;
      result.end_offset   <= rd_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tail      <= '0;
      k         <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_pend <= issue;
      if (issue) begin
        tail <= tail + twt_pkg::PTR_W'(1);
        k    <= last ? '0 : k + twt_pkg::LEN_W'(1);
      end
      if (rd_pend) begin
        out_valid <= 1'b1;
      end else if (pop_fire) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_slot_free: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> !out_valid)
    else $error("read data arrives while result register busy");

  a_load: assert property (@(posedge clk) disable iff (rst)
    rd_pend |=> out_valid)
    else $error("read data not loaded into result register");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pop |=> out_valid && $stable(result))
    else $error("waiting result lost or changed");

endmodule

// ===== sv/text_word_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// text_word_tokenizer_unit
// splits a byte stream into index words, one result beat per kept character
// ----------------------------------------------------------------------------
//
// channel   | handshake        | beat
// ----------+------------------+--------------------------------------------
// item      | push / full      | text_byte, end_of_text
// result    | empty / pop      | word_char, last_char, word_number, offsets
// config    | wr_en            | wr_index, wr_data (no read-back)
//
// a byte beat is taken while full is low; full rises only when
// the char ring holds two words' worth or the word queue is full
// each emitted character passes two steps in the back end: one ring read,
// one load of the result register; no new read issues while one is pending
// reset (rst, synchronous) restores config defaults and empties ring, queue
// and result register; no clearing pass is needed
// a stalled result side fills the ring or the queue, then holds full high
//
module text_word_tokenizer_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [twt_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [twt_pkg::CFG_W-1:0]     wr_data,
  input  logic                          push,
  output logic                          full,
  input  twt_pkg::item_t                item,
  output logic                          empty,
  input  logic                          pop,
  output twt_pkg::result_t              result
);

  // front to back traffic
  twt_pkg::char_wr_t          char_wr;
  logic [twt_pkg::PTR_W-1:0]  tail;
  twt_pkg::desc_t             desc_in;
  twt_pkg::desc_t             desc_out;
  logic                       desc_push;
  logic                       desc_full;
  logic                       desc_valid;
  logic                       desc_pop;

  // classify bytes, assemble words, decide keep or drop
  twt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .push      (push),
    .full      (full),
    .item      (item),
    .char_wr   (char_wr),
    .tail      (tail),
    .desc_push (desc_push),
    .desc      (desc_in),
    .desc_full (desc_full)
  );

  // kept words waiting for the emitter
  twt_desc_fifo u_desc_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (desc_push),
    .wdata (desc_in),
    .full  (desc_full),
    .rd    (desc_pop),
    .rdata (desc_out),
    .valid (desc_valid)
  );

  // walk the ring, one character beat per result
  twt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .char_wr    (char_wr),
    .tail       (tail),
    .desc       (desc_out),
    .desc_valid (desc_valid),
    .desc_pop   (desc_pop),
    .result     (result),
    .empty      (empty),
    .pop        (pop)
  );

endmodule
